### rtl/gstb_pkg.sv
// ============================================================================
// gstb_pkg
// Shared widths and register codes for the gridding sample tile binner.
// ============================================================================
package gstb_pkg;

    localparam int MAX_TILES_PER_SIDE = 16;

    // Field and register widths.
    localparam int COORD_W     = 16;
    localparam int GRID_W      = 13;
    localparam int TPS_W       = 5;
    localparam int KHW_W       = 12;
    localparam int TILE_IDX_W  = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    // Internal arithmetic widths.
    localparam int FRAC_W      = 16;
    localparam int CNT_W       = $clog2(MAX_TILES_PER_SIDE + 1);
    localparam int POS_W       = COORD_W + GRID_W;
    localparam int HW_W        = KHW_W + 8;
    localparam int N_W         = GRID_W + 1;
    localparam int RECIP_W     = FRAC_W + 1;
    localparam int MULT_N      = MAX_TILES_PER_SIDE + 2;
    localparam int MULT_W      = GRID_W + CNT_W;
    localparam int CMP_W       = MULT_W + FRAC_W + 1;
    localparam int NUM_EMIT    = 9;
    localparam int PICK_W      = $clog2(NUM_EMIT);
    localparam int NUM_STAGES  = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_PER_SIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HW      = 2'd2;

    // Emission slots, in output order.
    localparam int EM_HOME  = 0;
    localparam int EM_LEFT  = 1;
    localparam int EM_LU    = 2;
    localparam int EM_LD    = 3;
    localparam int EM_RIGHT = 4;
    localparam int EM_RU    = 5;
    localparam int EM_RD    = 6;
    localparam int EM_UP    = 7;
    localparam int EM_DOWN  = 8;

    typedef logic [MULT_W-1:0]     t_mult_arr [MULT_N];
    typedef logic [TILE_IDX_W-1:0] t_tile_arr [NUM_EMIT];

endpackage

### rtl/gridding_sample_tile_binner.sv
// A sample passes through the pipeline stages, the serializer and the output
// register before its first tile shows on o_valid. One result per cycle while
// i_stall is low; a sample of n tiles holds the serializer until all n are sent.
// The seven-stage arithmetic pipeline accepts a sample every cycle while it can drain.
// Reset is synchronous and active low: it empties the pipeline and loads
// grid_size 256, tiles_per_side 16 and kernel_half_width 512.
// ============================================================================
// gridding_sample_tile_binner
// Bins a k-space sample into its home grid tile and the neighbor tiles that
// the kernel half-width reaches, one tile index per output transfer.
// ============================================================================
module gridding_sample_tile_binner
    import gstb_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    // Sample input.
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_W-1:0]    i_coord_x,
    input  logic signed [COORD_W-1:0]    i_coord_y,
    // Tile output.
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [TILE_IDX_W-1:0]        o_tile_index,
    output logic signed [COORD_W-1:0]    o_echo_x,
    output logic signed [COORD_W-1:0]    o_echo_y,
    output logic                         o_is_last
);

    // ------------------------------------------------------------------
    // Configuration registers and their effective values.
    // ------------------------------------------------------------------
    logic [GRID_W-1:0] r_grid_size;
    logic [TPS_W-1:0]  r_tiles;
    logic [KHW_W-1:0]  r_khw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_W'(256);
            r_tiles     <= TPS_W'(16);
            r_khw       <= KHW_W'(512);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_SIZE:      r_grid_size <= i_cfg_data[GRID_W-1:0];
                CFG_TILES_PER_SIDE: r_tiles     <= i_cfg_data[TPS_W-1:0];
                CFG_KERNEL_HW:      r_khw       <= i_cfg_data[KHW_W-1:0];
                default: ;
            endcase
        end
    end

    logic [GRID_W-1:0] g_eff;
    logic [CNT_W-1:0]  t_eff;
    logic [HW_W-1:0]   h_fix;
    logic [N_W-1:0]    n_num;

    always_comb begin
        g_eff = (r_grid_size == '0) ? GRID_W'(1) : r_grid_size;
        if (r_tiles == '0) begin
            t_eff = CNT_W'(1);
        end else if (32'(r_tiles) > MAX_TILES_PER_SIDE) begin
            t_eff = CNT_W'(MAX_TILES_PER_SIDE);
        end else begin
            t_eff = CNT_W'(r_tiles);
        end
        h_fix = {r_khw, 8'b0};
        // Numerator of the rounded-up tile side.
        n_num = N_W'(g_eff) + N_W'(t_eff) - N_W'(1);
    end

    // Reciprocal table floor(2^16 / t), worked out at elaboration.
    logic [RECIP_W-1:0] recip_tab [MAX_TILES_PER_SIDE+1];
    assign recip_tab[0] = RECIP_W'(1 << FRAC_W);
    for (genvar k = 1; k <= MAX_TILES_PER_SIDE; k++) begin : g_recip
        localparam int RK = (1 << FRAC_W) / k;
        assign recip_tab[k] = RECIP_W'(RK);
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages move together when the last stage can
    // hand its sample to the serializer or is empty.
    // ------------------------------------------------------------------
    logic [NUM_STAGES:1] r_v;
    logic                adv;
    logic                ser_load;

    assign adv     = !r_v[NUM_STAGES] || ser_load;
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NUM_STAGES-1:1], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: positions in 16-bit fraction and the approximate tile side.
    // ------------------------------------------------------------------
    logic [N_W-1:0]           r1_q0;
    logic [POS_W-1:0]         r1_pos [2];
    logic signed [COORD_W-1:0] r1_ex, r1_ey;

    logic [N_W+RECIP_W-1:0]   n1_prod;
    logic [COORD_W-1:0]       n1_ux, n1_uy;

    always_comb begin
        n1_prod = (N_W+RECIP_W)'(n_num) * (N_W+RECIP_W)'(recip_tab[t_eff]);
        // Adding one half turns the sign bit into an offset-binary code.
        n1_ux   = {~i_coord_x[COORD_W-1], i_coord_x[COORD_W-2:0]};
        n1_uy   = {~i_coord_y[COORD_W-1], i_coord_y[COORD_W-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_q0     <= n1_prod[FRAC_W +: N_W];
            r1_pos[0] <= POS_W'(n1_ux) * POS_W'(g_eff);
            r1_pos[1] <= POS_W'(n1_uy) * POS_W'(g_eff);
            r1_ex     <= i_coord_x;
            r1_ey     <= i_coord_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the reciprocal estimate is low by at most one; fix it up.
    // ------------------------------------------------------------------
    logic [GRID_W-1:0]         r2_b;
    logic [POS_W-1:0]          r2_pos [2];
    logic signed [COORD_W-1:0] r2_ex, r2_ey;

    logic [N_W+CNT_W-1:0]      n2_qt;
    logic [N_W+CNT_W-1:0]      n2_rem;

    always_comb begin
        n2_qt  = (N_W+CNT_W)'(r1_q0) * (N_W+CNT_W)'(t_eff);
        n2_rem = (N_W+CNT_W)'(n_num) - n2_qt;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_b   <= (n2_rem >= (N_W+CNT_W)'(t_eff)) ? GRID_W'(r1_q0 + N_W'(1))
                                                      : GRID_W'(r1_q0);
            r2_pos <= r1_pos;
            r2_ex  <= r1_ex;
            r2_ey  <= r1_ey;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: tile boundaries, k times the tile side.
    // ------------------------------------------------------------------
    t_mult_arr                 r3_mult;
    logic [POS_W-1:0]          r3_pos [2];
    logic signed [COORD_W-1:0] r3_ex, r3_ey;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < MULT_N; k++) begin
                r3_mult[k] <= MULT_W'(k) * MULT_W'(r2_b);
            end
            r3_pos <= r2_pos;
            r3_ex  <= r2_ex;
            r3_ey  <= r2_ey;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: home column and row by counting the boundaries passed.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]          r4_idx [2];
    logic [MULT_W-1:0]         r4_b;
    logic [POS_W-1:0]          r4_pos [2];
    logic signed [COORD_W-1:0] r4_ex, r4_ey;

    logic [MAX_TILES_PER_SIDE-1:0] n4_ge [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n4_ge[a][0] = 1'b0;
            for (int k = 1; k < MAX_TILES_PER_SIDE; k++) begin
                n4_ge[a][k] = ((MULT_W+FRAC_W)'(r3_pos[a]) >= {r3_mult[k], FRAC_W'(0)});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < 2; a++) begin
                r4_idx[a] <= CNT_W'($countones(n4_ge[a]));
            end
            r4_b   <= r3_mult[1];
            r4_pos <= r3_pos;
            r4_ex  <= r3_ex;
            r4_ey  <= r3_ey;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: boundaries around the home tile and the kernel extent.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]          r5_idx [2];
    logic [MULT_W-1:0]         r5_b;
    logic [MULT_W-1:0]         r5_lo [2];
    logic [MULT_W-1:0]         r5_mid [2];
    logic [MULT_W-1:0]         r5_hi [2];
    logic [MULT_W-1:0]         r5_top [2];
    logic signed [CMP_W-1:0]   r5_pmh [2];
    logic signed [CMP_W-1:0]   r5_pph [2];
    logic signed [COORD_W-1:0] r5_ex, r5_ey;

    logic [MULT_W-1:0]         n5_base [2];
    logic signed [CMP_W-1:0]   n5_ps [2];
    logic signed [CMP_W-1:0]   n5_hs;

    always_comb begin
        n5_hs = CMP_W'(h_fix);
        for (int a = 0; a < 2; a++) begin
            n5_base[a] = MULT_W'(r4_idx[a]) * r4_b;
            n5_ps[a]   = CMP_W'(r4_pos[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < 2; a++) begin
                r5_lo[a]  <= n5_base[a] - r4_b;
                r5_mid[a] <= n5_base[a];
                r5_hi[a]  <= n5_base[a] + r4_b;
                r5_top[a] <= n5_base[a] + {r4_b[MULT_W-2:0], 1'b0};
                r5_pmh[a] <= n5_ps[a] - n5_hs;
                r5_pph[a] <= n5_ps[a] + n5_hs;
            end
            r5_idx <= r4_idx;
            r5_b   <= r4_b;
            r5_ex  <= r4_ex;
            r5_ey  <= r4_ey;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: does the kernel reach the tile before or after the home one.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]          r6_idx [2];
    logic                      r6_neg [2];
    logic                      r6_pos [2];
    logic signed [COORD_W-1:0] r6_ex, r6_ey;

    logic signed [CMP_W-1:0]   n6_div;
    logic signed [CMP_W-1:0]   n6_lo [2];
    logic signed [CMP_W-1:0]   n6_mid [2];
    logic signed [CMP_W-1:0]   n6_hi [2];
    logic signed [CMP_W-1:0]   n6_top [2];
    logic                      n6_lower_ok [2];
    logic                      n6_neg [2];
    logic                      n6_pos [2];

    always_comb begin
        n6_div = $signed({1'b0, r5_b, FRAC_W'(0)});
        for (int a = 0; a < 2; a++) begin
            n6_lo[a]  = $signed({1'b0, r5_lo[a], FRAC_W'(0)});
            n6_mid[a] = $signed({1'b0, r5_mid[a], FRAC_W'(0)});
            n6_hi[a]  = $signed({1'b0, r5_hi[a], FRAC_W'(0)});
            n6_top[a] = $signed({1'b0, r5_top[a], FRAC_W'(0)});
            // Next to the first tile, a lower bound that truncates toward
            // zero still lands in tile 0 while it stays above minus one side.
            n6_lower_ok[a] = (r5_idx[a] == CNT_W'(1)) ? (r5_pmh[a] > -n6_div)
                                                      : (r5_pmh[a] >= n6_lo[a]);
            n6_neg[a] = (r5_idx[a] != '0) && (r5_pmh[a] < n6_mid[a]) && n6_lower_ok[a];
            n6_pos[a] = ((CNT_W+1)'(r5_idx[a]) + (CNT_W+1)'(1) < (CNT_W+1)'(t_eff))
                        && (r5_pph[a] >= n6_hi[a]) && (r5_pph[a] < n6_top[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_idx <= r5_idx;
            r6_neg <= n6_neg;
            r6_pos <= n6_pos;
            r6_ex  <= r5_ex;
            r6_ey  <= r5_ey;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: tile indexes of all candidates and the emission mask.
    // ------------------------------------------------------------------
    t_tile_arr                 r7_tile;
    logic [NUM_EMIT-1:0]       r7_mask;
    logic signed [COORD_W-1:0] r7_ex, r7_ey;

    logic [TILE_IDX_W-1:0]     n7_t8;
    logic [TILE_IDX_W-1:0]     n7_row_m, n7_row_0, n7_row_p;
    logic [TILE_IDX_W-1:0]     n7_col_m, n7_col_0, n7_col_p;
    logic [TILE_IDX_W-1:0]     n7_by;
    t_tile_arr                 n7_tile;
    logic [NUM_EMIT-1:0]       n7_mask;
    logic                      n7_left, n7_right, n7_up, n7_down;

    always_comb begin
        n7_t8    = TILE_IDX_W'(t_eff);
        n7_by    = TILE_IDX_W'(r6_idx[1]);
        n7_row_m = TILE_IDX_W'((n7_by - TILE_IDX_W'(1)) * n7_t8);
        n7_row_0 = TILE_IDX_W'(n7_by * n7_t8);
        n7_row_p = TILE_IDX_W'((n7_by + TILE_IDX_W'(1)) * n7_t8);
        n7_col_0 = TILE_IDX_W'(r6_idx[0]);
        n7_col_m = n7_col_0 - TILE_IDX_W'(1);
        n7_col_p = n7_col_0 + TILE_IDX_W'(1);

        n7_tile[EM_HOME]  = n7_row_0 + n7_col_0;
        n7_tile[EM_LEFT]  = n7_row_0 + n7_col_m;
        n7_tile[EM_LU]    = n7_row_m + n7_col_m;
        n7_tile[EM_LD]    = n7_row_p + n7_col_m;
        n7_tile[EM_RIGHT] = n7_row_0 + n7_col_p;
        n7_tile[EM_RU]    = n7_row_m + n7_col_p;
        n7_tile[EM_RD]    = n7_row_p + n7_col_p;
        n7_tile[EM_UP]    = n7_row_m + n7_col_0;
        n7_tile[EM_DOWN]  = n7_row_p + n7_col_0;

        n7_left  = r6_neg[0];
        n7_right = r6_pos[0];
        n7_up    = r6_neg[1];
        n7_down  = r6_pos[1];

        n7_mask           = '0;
        n7_mask[EM_HOME]  = 1'b1;
        n7_mask[EM_LEFT]  = n7_left;
        n7_mask[EM_LU]    = n7_left && n7_up;
        n7_mask[EM_LD]    = n7_left && n7_down;
        n7_mask[EM_RIGHT] = n7_right;
        n7_mask[EM_RU]    = n7_right && n7_up;
        n7_mask[EM_RD]    = n7_right && n7_down;
        n7_mask[EM_UP]    = n7_up;
        n7_mask[EM_DOWN]  = n7_down;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_tile <= n7_tile;
            r7_mask <= n7_mask;
            r7_ex   <= r6_ex;
            r7_ey   <= r6_ey;
        end
    end

    // ------------------------------------------------------------------
    // Serializer: walks the mask from the lowest set bit up, one tile per
    // output transfer, and takes the next sample as it sends the last tile.
    // ------------------------------------------------------------------
    logic [NUM_EMIT-1:0]       r_ser_mask;
    t_tile_arr                 r_ser_tile;
    logic signed [COORD_W-1:0] r_ser_ex, r_ser_ey;

    logic                      r_out_valid;
    logic [TILE_IDX_W-1:0]     r_out_tile;
    logic signed [COORD_W-1:0] r_out_ex, r_out_ey;
    logic                      r_out_last;

    logic                      ser_busy;
    logic                      out_load;
    logic                      emit;
    logic [PICK_W-1:0]         pick;
    logic [NUM_EMIT-1:0]       rest;

    always_comb begin
        pick = '0;
        for (int k = NUM_EMIT - 1; k >= 0; k--) begin
            if (r_ser_mask[k]) begin
                pick = PICK_W'(k);
            end
        end
        rest     = r_ser_mask & (r_ser_mask - NUM_EMIT'(1));
        ser_busy = (r_ser_mask != '0);
        out_load = !r_out_valid || !i_stall;
        emit     = ser_busy && out_load;
        ser_load = !ser_busy || (emit && (rest == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_mask  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ser_load) begin
                r_ser_mask <= r_v[NUM_STAGES] ? r7_mask : '0;
            end else if (emit) begin
                r_ser_mask <= rest;
            end
            if (out_load) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_ser_tile <= r7_tile;
            r_ser_ex   <= r7_ex;
            r_ser_ey   <= r7_ey;
        end
        if (emit) begin
            r_out_tile <= r_ser_tile[pick];
            r_out_ex   <= r_ser_ex;
            r_out_ey   <= r_ser_ey;
            r_out_last <= (rest == '0);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tile_index = r_out_tile;
    assign o_echo_x     = r_out_ex;
    assign o_echo_y     = r_out_ey;
    assign o_is_last    = r_out_last;

`ifndef ASSERT_OFF
    // The home tile is always part of a sample's emission set.
    a_home_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NUM_STAGES] |-> r7_mask[EM_HOME])
        else $error("sample reached the serializer without its home tile");

    // The home column and row always lie inside the grid.
    a_home_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[6] |-> ((r6_idx[0] < t_eff) && (r6_idx[1] < t_eff)))
        else $error("home tile position outside the grid");

    // A stalled output leaves the pending tiles untouched.
    a_ser_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ser_busy && r_out_valid && i_stall) |=> $stable(r_ser_mask))
        else $error("serializer advanced while the output was stalled");

    // Reset empties the serializer and the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && (r_ser_mask == '0)))
        else $error("output not empty after reset");
`endif

endmodule

### tb/sv/gridding_sample_tile_binner_test.sv
// ============================================================================
// gridding_sample_tile_binner_test
// Self-checking testbench for the sample tile binner. A directed table covers
// the grid corners and the register extremes. Random phases with
// boundary-seeking coordinates follow. Every output transfer is checked against
// the known tiles of the directed table or an in-bench tile predictor.
// ============================================================================
module gridding_sample_tile_binner_test;
    import gstb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int N_DIR = 32;
    localparam int N_PHASES = 6;
    localparam int PHASE_ITEMS = 14;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    // A sample row carries coordinates in a and b and up to four known tiles.
    // A register row carries the index in a and the data in b.
    typedef struct {
        t_row_kind   kind;
        logic [15:0] a;
        logic [15:0] b;
        int          n_typed;
        logic [31:0] tiles;
    } t_stim_row;

    typedef struct {
        logic [TILE_IDX_W-1:0]     tile;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic                      last;
    } t_tile_xfer;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [COORD_W-1:0] i_coord_x;
    logic signed [COORD_W-1:0] i_coord_y;
    logic                      o_valid;
    logic                      i_stall;
    logic [TILE_IDX_W-1:0]     o_tile_index;
    logic signed [COORD_W-1:0] o_echo_x;
    logic signed [COORD_W-1:0] o_echo_y;
    logic                      o_is_last;

    // Predictor copy of the registers.
    logic [GRID_W-1:0] grid_cells;
    logic [TPS_W-1:0]  tiles_side;
    logic [KHW_W-1:0]  half_width;

    t_tile_xfer pending_tiles[$];
    t_stim_row  dir_tab [N_DIR];

    int src_idle_pct;
    int sink_stall_pct;
    int mismatches;
    int samples_in;
    int tiles_out;
    int reg_writes;
    int quiet_cycles;

    gridding_sample_tile_binner dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tile_index (o_tile_index),
        .o_echo_x     (o_echo_x),
        .o_echo_y     (o_echo_y),
        .o_is_last    (o_is_last)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic longint eff_grid();
        return (grid_cells == 0) ? 1 : longint'(grid_cells);
    endfunction

    function automatic longint eff_tiles();
        longint t;
        t = (tiles_side == 0) ? 1 : longint'(tiles_side);
        if (t > MAX_TILES_PER_SIDE) begin
            t = MAX_TILES_PER_SIDE;
        end
        return t;
    endfunction

    // Works out every tile a sample lands in, home tile first, and queues them.
    function automatic void bin_sample(logic [15:0] cx, logic [15:0] cy);
        longint g, t, dv, px, py, h, bx, by, lbx, ubx, lby, uby;
        longint rows[$];
        longint cols[$];
        bit left, right, up, down;
        t_tile_xfer e;
        g = eff_grid();
        t = eff_tiles();
        dv = ((g + t - 1) / t) * 65536;
        px = (longint'($signed(cx)) + 32768) * g;
        py = (longint'($signed(cy)) + 32768) * g;
        h = longint'(half_width) * 256;
        // SystemVerilog division truncates toward zero, as the binning needs.
        bx = px / dv;
        by = py / dv;
        lbx = (px - h) / dv;
        ubx = (px + h) / dv;
        lby = (py - h) / dv;
        uby = (py + h) / dv;
        left = (lbx == bx - 1) && (lbx >= 0);
        right = (ubx == bx + 1) && (ubx < t);
        up = (lby == by - 1) && (lby >= 0);
        down = (uby == by + 1) && (uby < t);
        rows.push_back(by);
        cols.push_back(bx);
        if (left) begin
            rows.push_back(by);
            cols.push_back(lbx);
            if (up) begin
                rows.push_back(lby);
                cols.push_back(lbx);
            end
            if (down) begin
                rows.push_back(uby);
                cols.push_back(lbx);
            end
        end
        if (right) begin
            rows.push_back(by);
            cols.push_back(ubx);
            if (up) begin
                rows.push_back(lby);
                cols.push_back(ubx);
            end
            if (down) begin
                rows.push_back(uby);
                cols.push_back(ubx);
            end
        end
        if (up) begin
            rows.push_back(lby);
            cols.push_back(bx);
        end
        if (down) begin
            rows.push_back(uby);
            cols.push_back(bx);
        end
        for (int k = 0; k < rows.size(); k++) begin
            e.tile = TILE_IDX_W'(rows[k] * t + cols[k]);
            e.ex = cx;
            e.ey = cy;
            e.last = (k == rows.size() - 1);
            pending_tiles.push_back(e);
        end
    endfunction

    // Coordinates near a tile edge, within reach of the kernel, or fully random.
    function automatic logic [15:0] pick_coord();
        longint g, t, b, k, j, c;
        if ($urandom_range(99) < 35) begin
            return 16'($urandom());
        end
        g = eff_grid();
        t = eff_tiles();
        b = (g + t - 1) / t;
        k = $urandom_range(t);
        j = (longint'(half_width) * 256) / g + 64;
        if (j > 32767) begin
            j = 32767;
        end
        c = (k * b * 65536) / g - 32768 + longint'($urandom_range(2 * j)) - j;
        if (c < -32768) begin
            c = -32768;
        end
        if (c > 32767) begin
            c = 32767;
        end
        return c[15:0];
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    // Register writes happen only once every expected tile has come out.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_valid <= 1'b0;
        while (pending_tiles.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_GRID_SIZE:      grid_cells = data[GRID_W-1:0];
            CFG_TILES_PER_SIDE: tiles_side = data[TPS_W-1:0];
            CFG_KERNEL_HW:      half_width = data[KHW_W-1:0];
            default:            ;
        endcase
        reg_writes++;
    endtask

    // Presents one sample and queues its tiles once the transfer completes.
    task automatic send_sample(input logic [15:0] cx, input logic [15:0] cy,
                               input int n_typed, input logic [31:0] typed);
        t_tile_xfer e;
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_coord_x <= cx;
        i_coord_y <= cy;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        samples_in++;
        if (n_typed == 0) begin
            bin_sample(cx, cy);
        end else begin
            for (int k = 0; k < n_typed; k++) begin
                e.tile = typed[8*k +: 8];
                e.ex = cx;
                e.ey = cy;
                e.last = (k == n_typed - 1);
                pending_tiles.push_back(e);
            end
        end
    endtask

    // Output checker and receiver stall generator.
    always @(posedge i_clk) begin
        t_tile_xfer e;
        if (i_rst_n && o_valid && !i_stall) begin
            tiles_out++;
            if (pending_tiles.size() == 0) begin
                flag_error($sformatf("unexpected tile %0d x=%0d y=%0d last=%0b",
                                     o_tile_index, o_echo_x, o_echo_y, o_is_last));
            end else begin
                e = pending_tiles.pop_front();
                if (e.tile !== o_tile_index || e.ex !== o_echo_x || e.ey !== o_echo_y
                        || e.last !== o_is_last) begin
                    flag_error($sformatf(
                        "expected tile %0d x=%0d y=%0d last=%0b, got %0d x=%0d y=%0d last=%0b",
                        e.tile, e.ex, e.ey, e.last,
                        o_tile_index, o_echo_x, o_echo_y, o_is_last));
                end
            end
        end
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Watchdog on cycles without any transfer or register write.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d tiles outstanding",
                     QUIET_LIMIT, pending_tiles.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] gsel, tsel, ksel;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_coord_x <= '0;
        i_coord_y <= '0;
        i_stall <= 1'b0;
        quiet_cycles = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        mismatches = 0;
        samples_in = 0;
        tiles_out = 0;
        reg_writes = 0;
        grid_cells = 13'd256;
        tiles_side = 5'd16;
        half_width = 12'd512;

        // Known tiles are for the reset grid of 256 cells in 16 tiles with a
        // two-cell half-width, the no-kernel case, and the single-tile grids.
        dir_tab = '{
            '{ROW_SAMPLE, 16'h8000, 16'h8000, 1, 32'h0000_0000},
            '{ROW_SAMPLE, 16'h7FFF, 16'h8000, 1, 32'h0000_000F},
            '{ROW_SAMPLE, 16'h8000, 16'h7FFF, 1, 32'h0000_00F0},
            '{ROW_SAMPLE, 16'h7FFF, 16'h7FFF, 1, 32'h0000_00FF},
            '{ROW_SAMPLE, 16'h0000, 16'h0000, 4, 32'h7877_8788},
            '{ROW_SAMPLE, 16'hFFFF, 16'h0000, 0, 32'h0},
            '{ROW_SAMPLE, 16'h1000, 16'hF000, 0, 32'h0},
            '{ROW_CFG,    16'(CFG_KERNEL_HW), 16'd0, 0, 32'h0},
            '{ROW_SAMPLE, 16'h0000, 16'h0000, 1, 32'h0000_0088},
            '{ROW_CFG,    16'(CFG_GRID_SIZE), 16'd0, 0, 32'h0},
            '{ROW_SAMPLE, 16'h1234, 16'h5678, 1, 32'h0000_0000},
            '{ROW_CFG,    16'(CFG_TILES_PER_SIDE), 16'd0, 0, 32'h0},
            '{ROW_CFG,    16'(CFG_KERNEL_HW), 16'd4095, 0, 32'h0},
            '{ROW_SAMPLE, 16'h7FFF, 16'h8000, 0, 32'h0},
            '{ROW_CFG,    16'(CFG_GRID_SIZE), 16'd8191, 0, 32'h0},
            '{ROW_CFG,    16'(CFG_TILES_PER_SIDE), 16'd31, 0, 32'h0},
            '{ROW_SAMPLE, 16'h7FFF, 16'h7FFF, 0, 32'h0},
            '{ROW_SAMPLE, 16'h8001, 16'h7FFE, 0, 32'h0},
            '{ROW_CFG,    16'(CFG_SPARE_IDX), 16'd5, 0, 32'h0},
            '{ROW_SAMPLE, 16'h0000, 16'h0000, 0, 32'h0},
            '{ROW_CFG,    16'(CFG_GRID_SIZE), 16'd16, 0, 32'h0},
            '{ROW_CFG,    16'(CFG_TILES_PER_SIDE), 16'd16, 0, 32'h0},
            '{ROW_SAMPLE, 16'h4000, 16'hC000, 0, 32'h0},
            '{ROW_CFG,    16'(CFG_KERNEL_HW), 16'd128, 0, 32'h0},
            '{ROW_SAMPLE, 16'h0800, 16'hF800, 0, 32'h0},
            '{ROW_CFG,    16'(CFG_GRID_SIZE), 16'd4096, 0, 32'h0},
            '{ROW_CFG,    16'(CFG_TILES_PER_SIDE), 16'd1, 0, 32'h0},
            '{ROW_SAMPLE, 16'h7FFF, 16'h8000, 1, 32'h0000_0000},
            '{ROW_CFG,    16'(CFG_TILES_PER_SIDE), 16'd5, 0, 32'h0},
            '{ROW_CFG,    16'(CFG_KERNEL_HW), 16'd2048, 0, 32'h0},
            '{ROW_SAMPLE, 16'h2000, 16'hE000, 0, 32'h0},
            '{ROW_SAMPLE, 16'hAAAA, 16'h5555, 0, 32'h0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                write_reg(dir_tab[r].a[CFG_IDX_W-1:0], dir_tab[r].b[CFG_DATA_W-1:0]);
            end else begin
                send_sample(dir_tab[r].a, dir_tab[r].b, dir_tab[r].n_typed, dir_tab[r].tiles);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            case ($urandom_range(5))
                0: gsel = 13'd256;
                1: gsel = 13'd4096;
                2: gsel = 13'($urandom_range(1, 64));
                3: gsel = 13'($urandom_range(1, 4096));
                4: gsel = 13'($urandom_range(4097, 8191));
                default: gsel = 13'd0;
            endcase
            case ($urandom_range(4))
                0: tsel = 13'd16;
                1: tsel = 13'd1;
                2: tsel = 13'($urandom_range(2, 15));
                3: tsel = 13'($urandom_range(17, 31));
                default: tsel = 13'd0;
            endcase
            case ($urandom_range(3))
                0: ksel = 13'd0;
                1: ksel = 13'd4095;
                2: ksel = 13'($urandom_range(1, 1024));
                default: ksel = 13'($urandom_range(0, 4095));
            endcase
            write_reg(CFG_GRID_SIZE, gsel);
            write_reg(CFG_TILES_PER_SIDE, tsel);
            write_reg(CFG_KERNEL_HW, ksel);
            if (p == 0) begin
                write_reg(CFG_SPARE_IDX, 13'($urandom()));
            end
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
                default: begin src_idle_pct = 7; sink_stall_pct = 7; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_sample(pick_coord(), pick_coord(), 0, 32'h0);
            end
        end

        i_valid <= 1'b0;
        i_cfg_we <= 1'b0;
        while (pending_tiles.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("Binned %0d samples into %0d checked tile transfers across %0d register writes,",
                 samples_in, tiles_out, reg_writes);
        $display("with corner, boundary and random coordinates under four idle patterns.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
